// ===== rtl/ede_pkg.sv =====
// package for the edit distance engine: types, codes and the control store
`default_nettype none

package ede_pkg;

    localparam int MAX_FIRST_LEN  = 64;
    localparam int MAX_SECOND_LEN = 65535;
    localparam int FIRST_AW       = $clog2(MAX_FIRST_LEN);
    localparam int LEN_W          = $clog2(MAX_FIRST_LEN + 1);
    localparam int DIST_W         = 16;
    localparam int CHAR_W         = 8;
    localparam int CMD_W          = 2;
    localparam int STATUS_W       = 3;
    localparam int UA_W           = 5;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FEED   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REPORT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_BAD    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FIRST_FULL   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FIRST_LOCKED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SECOND_SAT   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BAD_CMD      = 3'd4;

    localparam logic [DIST_W-1:0] SECOND_MAX = DIST_W'(MAX_SECOND_LEN);
    localparam logic [LEN_W-1:0]  FIRST_MAX  = LEN_W'(MAX_FIRST_LEN);

    // control store addresses
    localparam logic [UA_W-1:0] UA_APPEND      = 5'd0;
    localparam logic [UA_W-1:0] UA_APPEND_FULL = 5'd1;
    localparam logic [UA_W-1:0] UA_APPEND_DO   = 5'd2;
    localparam logic [UA_W-1:0] UA_FEED        = 5'd3;
    localparam logic [UA_W-1:0] UA_FEED_PRIME  = 5'd4;
    localparam logic [UA_W-1:0] UA_FEED_WALK   = 5'd5;
    localparam logic [UA_W-1:0] UA_FEED_DONE   = 5'd6;
    localparam logic [UA_W-1:0] UA_REPORT      = 5'd7;
    localparam logic [UA_W-1:0] UA_CLEAR       = 5'd8;
    localparam logic [UA_W-1:0] UA_ST_LOCKED   = 5'd9;
    localparam logic [UA_W-1:0] UA_ST_FULL     = 5'd10;
    localparam logic [UA_W-1:0] UA_ST_SAT      = 5'd11;
    localparam logic [UA_W-1:0] UA_ST_BAD      = 5'd12;
    localparam logic [UA_W-1:0] UA_ST_OK       = 5'd13;
    localparam logic [UA_W-1:0] UA_EMIT        = 5'd14;
    localparam logic [UA_W-1:0] UA_FETCH       = 5'd15;
    localparam logic [UA_W-1:0] UA_DISPATCH    = 5'd16;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CAPTURE,
        OP_APPEND,
        OP_PRIME,
        OP_WALK,
        OP_COUNT_INC,
        OP_SNAP,
        OP_CLEAR,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NOT_VALID,
        COND_LOCKED,
        COND_FULL,
        COND_SAT,
        COND_LEN0,
        COND_MORE,
        COND_OUT_BUSY,
        COND_DISPATCH
    } cond_t;

    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] status;
        cond_t               cond;
        logic [UA_W-1:0]     target;
    } uword_t;

    typedef struct packed {
        op_t                 op;
        logic [STATUS_W-1:0] status;
    } ctrl_t;

    typedef struct packed {
        logic             locked;
        logic             full;
        logic             sat;
        logic             len0;
        logic             more;
        logic [CMD_W-1:0] cmd;
    } flags_t;

    function automatic uword_t ucode_rom(input logic [UA_W-1:0] addr);
        uword_t w;
        w = '{op: OP_NOP, status: ST_OK, cond: COND_ALWAYS, target: UA_FETCH};
        unique case (addr)
            UA_APPEND:      w = '{OP_NOP,       ST_OK,           COND_LOCKED,    UA_ST_LOCKED};
            UA_APPEND_FULL: w = '{OP_NOP,       ST_OK,           COND_FULL,      UA_ST_FULL};
            UA_APPEND_DO:   w = '{OP_APPEND,    ST_OK,           COND_ALWAYS,    UA_ST_OK};
            UA_FEED:        w = '{OP_NOP,       ST_OK,           COND_SAT,       UA_ST_SAT};
            UA_FEED_PRIME:  w = '{OP_PRIME,     ST_OK,           COND_LEN0,      UA_FEED_DONE};
            UA_FEED_WALK:   w = '{OP_WALK,      ST_OK,           COND_MORE,      UA_FEED_WALK};
            UA_FEED_DONE:   w = '{OP_COUNT_INC, ST_OK,           COND_ALWAYS,    UA_ST_OK};
            UA_REPORT:      w = '{OP_SNAP,      ST_OK,           COND_NEVER,     UA_CLEAR};
            UA_CLEAR:       w = '{OP_CLEAR,     ST_OK,           COND_ALWAYS,    UA_EMIT};
            UA_ST_LOCKED:   w = '{OP_SNAP,      ST_FIRST_LOCKED, COND_ALWAYS,    UA_EMIT};
            UA_ST_FULL:     w = '{OP_SNAP,      ST_FIRST_FULL,   COND_ALWAYS,    UA_EMIT};
            UA_ST_SAT:      w = '{OP_SNAP,      ST_SECOND_SAT,   COND_ALWAYS,    UA_EMIT};
            UA_ST_BAD:      w = '{OP_SNAP,      ST_BAD_CMD,      COND_ALWAYS,    UA_EMIT};
            UA_ST_OK:       w = '{OP_SNAP,      ST_OK,           COND_NEVER,     UA_EMIT};
            UA_EMIT:        w = '{OP_EMIT,      ST_OK,           COND_OUT_BUSY,  UA_EMIT};
            UA_FETCH:       w = '{OP_CAPTURE,   ST_OK,           COND_NOT_VALID, UA_FETCH};
            UA_DISPATCH:    w = '{OP_NOP,       ST_OK,           COND_DISPATCH,  UA_FETCH};
            default:        w = '{OP_NOP,       ST_OK,           COND_ALWAYS,    UA_FETCH};
        endcase
        return w;
    endfunction

    function automatic logic [UA_W-1:0] dispatch_target(input logic [CMD_W-1:0] cmd);
        logic [UA_W-1:0] t;
        t = UA_ST_BAD;
        unique case (cmd)
            CMD_APPEND: t = UA_APPEND;
            CMD_FEED:   t = UA_FEED;
            CMD_REPORT: t = UA_REPORT;
            CMD_BAD:    t = UA_ST_BAD;
            default:    t = UA_ST_BAD;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ede_sequencer.sv =====
// microcode sequencer: step counter, control store and branch logic
`default_nettype none

module ede_sequencer (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire logic           out_busy,
    input  ede_pkg::flags_t     flags,
    output ede_pkg::ctrl_t      ctrl
);
    import ede_pkg::*;

    logic [UA_W-1:0] upc_reg;
    logic [UA_W-1:0] upc_next;
    uword_t          uword;
    logic            taken;

    assign uword = ucode_rom(upc_reg);

    always_comb begin
        taken = 1'b0;
        unique case (uword.cond)
            COND_NEVER:     taken = 1'b0;
            COND_ALWAYS:    taken = 1'b1;
            COND_NOT_VALID: taken = !in_valid;
            COND_LOCKED:    taken = flags.locked;
            COND_FULL:      taken = flags.full;
            COND_SAT:       taken = flags.sat;
            COND_LEN0:      taken = flags.len0;
            COND_MORE:      taken = flags.more;
            COND_OUT_BUSY:  taken = out_busy;
            COND_DISPATCH:  taken = 1'b1;
            default:        taken = 1'b0;
        endcase
    end

    always_comb begin
        if (uword.cond == COND_DISPATCH) begin
            upc_next = dispatch_target(flags.cmd);
        end else if (taken) begin
            upc_next = uword.target;
        end else begin
            upc_next = upc_reg + UA_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= UA_FETCH;
        end else begin
            upc_reg <= upc_next;
        end
    end

    assign ctrl.op     = uword.op;
    assign ctrl.status = uword.status;

endmodule

`default_nettype wire

// ===== rtl/ede_datapath.sv =====
// datapath: string and column memories, counters and the cell update
`default_nettype none

module ede_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  ede_pkg::ctrl_t                     ctrl,
    input  wire logic                          in_valid,
    input  wire logic [ede_pkg::CMD_W-1:0]     in_command,
    input  wire logic [ede_pkg::CHAR_W-1:0]    in_ch,
    output ede_pkg::flags_t                    flags,
    output logic      [ede_pkg::DIST_W-1:0]    res_distance,
    output logic      [ede_pkg::STATUS_W-1:0]  res_status
);
    import ede_pkg::*;

    logic [CHAR_W-1:0] chars_mem [MAX_FIRST_LEN];
    logic [DIST_W-1:0] dp_mem    [MAX_FIRST_LEN];

    logic [CMD_W-1:0]    cmd_reg;
    logic [CHAR_W-1:0]   ch_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    len_next;
    logic [DIST_W-1:0]   count_reg;
    logic [DIST_W-1:0]   count_next;
    logic [FIRST_AW-1:0] idx_reg;
    logic [DIST_W-1:0]   above_reg;
    logic [DIST_W-1:0]   diag_reg;
    logic [DIST_W-1:0]   last_reg;
    logic [DIST_W-1:0]   res_distance_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic [CHAR_W-1:0]   chars_rd_reg;
    logic [DIST_W-1:0]   dp_rd_reg;

    logic [FIRST_AW-1:0] raddr;
    logic [DIST_W:0]     del_cost;
    logic [DIST_W:0]     ins_cost;
    logic [DIST_W:0]     sub_cost;
    logic [DIST_W:0]     min_ab;
    logic [DIST_W:0]     cell_min;
    logic [DIST_W-1:0]   cell_val;
    logic [DIST_W-1:0]   cur_dist;

    // cell update for one first-string position
    always_comb begin
        del_cost = {1'b0, dp_rd_reg} + (DIST_W+1)'(1);
        ins_cost = {1'b0, above_reg} + (DIST_W+1)'(1);
        sub_cost = {1'b0, diag_reg} + (DIST_W+1)'(chars_rd_reg != ch_reg);
        min_ab   = (del_cost < ins_cost) ? del_cost : ins_cost;
        cell_min = (min_ab < sub_cost) ? min_ab : sub_cost;
        cell_val = cell_min[DIST_W-1:0];
    end

    assign cur_dist = (len_reg == '0) ? count_reg : last_reg;
    assign raddr    = (ctrl.op == OP_WALK) ? (idx_reg + FIRST_AW'(1)) : '0;

    always_ff @(posedge aclk) begin
        chars_rd_reg <= chars_mem[raddr];
        dp_rd_reg    <= dp_mem[raddr];
        if (ctrl.op == OP_APPEND) begin
            chars_mem[len_reg[FIRST_AW-1:0]] <= ch_reg;
            dp_mem[len_reg[FIRST_AW-1:0]]    <= DIST_W'(len_reg) + DIST_W'(1);
        end else if (ctrl.op == OP_WALK) begin
            dp_mem[idx_reg] <= cell_val;
        end
    end

    always_comb begin
        len_next   = len_reg;
        count_next = count_reg;
        case (ctrl.op)
            OP_APPEND:    len_next   = len_reg + LEN_W'(1);
            OP_COUNT_INC: count_next = count_reg + DIST_W'(1);
            OP_CLEAR: begin
                len_next   = '0;
                count_next = '0;
            end
            default: begin
                len_next   = len_reg;
                count_next = count_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            count_reg <= '0;
        end else begin
            len_reg   <= len_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_CAPTURE: begin
                if (in_valid) begin
                    cmd_reg <= in_command;
                    ch_reg  <= in_ch;
                end
            end
            OP_APPEND: last_reg <= DIST_W'(len_reg) + DIST_W'(1);
            OP_PRIME: begin
                above_reg <= count_reg + DIST_W'(1);
                diag_reg  <= count_reg;
                idx_reg   <= '0;
            end
            OP_WALK: begin
                above_reg <= cell_val;
                diag_reg  <= dp_rd_reg;
                last_reg  <= cell_val;
                idx_reg   <= idx_reg + FIRST_AW'(1);
            end
            OP_SNAP: begin
                res_distance_reg <= cur_dist;
                res_status_reg   <= ctrl.status;
            end
            default: begin
            end
        endcase
    end

    assign flags.locked = (count_reg != '0);
    assign flags.full   = (len_reg == FIRST_MAX);
    assign flags.sat    = (count_reg == SECOND_MAX);
    assign flags.len0   = (len_reg == '0);
    assign flags.more   = ((LEN_W'(idx_reg) + LEN_W'(1)) < len_reg);
    assign flags.cmd    = cmd_reg;

    assign res_distance = res_distance_reg;
    assign res_status   = res_status_reg;

    ap_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= FIRST_MAX)
        else $error("first string length past capacity");

    ap_walk_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_WALK |-> LEN_W'(idx_reg) < len_reg)
        else $error("column walk past stored first string");

    ap_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.op == OP_COUNT_INC |=> count_reg == $past(count_reg) + DIST_W'(1))
        else $error("second count did not advance by one");

endmodule

`default_nettype wire

// ===== rtl/edit_distance_engine_unit.sv =====
// Levenshtein edit distance engine, top level with result register.
//
// Input channel s_*: one transaction carries s_command and s_ch. Command 0
// appends s_ch to the stored first string (up to 64 bytes), command 1 feeds
// one byte of the second string, command 2 reports and clears, command 3 is
// rejected. Every input transaction yields exactly one result transaction
// on m_* with m_distance and m_status (0 ok, 1 first full, 2 first locked,
// 3 second saturated, 4 bad command).
// One item at a time runs through a microcoded sequencer. A feed's time
// from acceptance to result valid grows with the first string length, set
// by the walk over the column memory at one entry per cycle; append, report
// and status-only items skip the walk.
// The next input transaction can be accepted from the cycle after the result
// is loaded.
// The result sits in an output register, so the next input transaction is
// accepted while a result still waits; if the receiver stalls with m_ready
// low, the sequencer holds before loading the next result.
// Reset clears the lengths and the handshake state; memories need no clearing
// and the sequencer starts at the fetch step.
`default_nettype none

module edit_distance_engine_unit (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [ede_pkg::CMD_W-1:0]     s_command,
    input  wire logic [ede_pkg::CHAR_W-1:0]    s_ch,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [ede_pkg::DIST_W-1:0]    m_distance,
    output logic      [ede_pkg::STATUS_W-1:0]  m_status
);
    import ede_pkg::*;

    ctrl_t               ctrl;
    flags_t              flags;
    logic [DIST_W-1:0]   res_distance;
    logic [STATUS_W-1:0] res_status;
    logic                out_busy;
    logic                emit;

    logic                m_valid_reg;
    logic                m_valid_next;
    logic [DIST_W-1:0]   m_distance_reg;
    logic [STATUS_W-1:0] m_status_reg;

    ede_sequencer u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .out_busy (out_busy),
        .flags    (flags),
        .ctrl     (ctrl)
    );

    ede_datapath u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .in_valid     (s_valid),
        .in_command   (s_command),
        .in_ch        (s_ch),
        .flags        (flags),
        .res_distance (res_distance),
        .res_status   (res_status)
    );

    assign s_ready  = (ctrl.op == OP_CAPTURE);
    assign out_busy = m_valid_reg && !m_ready;
    assign emit     = (ctrl.op == OP_EMIT) && !out_busy;

    always_comb begin
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_distance_reg <= res_distance;
            m_status_reg   <= res_status;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_distance = m_distance_reg;
    assign m_status   = m_status_reg;

    ap_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second transaction taken while one is in flight");

    ap_emit_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |=> m_valid)
        else $error("result not presented after load");

    ap_rise_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(emit))
        else $error("result valid without a load");

    ap_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_BAD_CMD)
        else $error("undefined status code on result");

endmodule

`default_nettype wire
